// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent ends.
`define QVR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent ends.
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Field widths and beat types of the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int Q_W   = 16;  // quaternion component, signed Q1.f
  localparam int VEC_W = 24;  // vector component, signed integer

  typedef struct packed {
    logic signed [Q_W-1:0]   q_w;
    logic signed [Q_W-1:0]   q_x;
    logic signed [Q_W-1:0]   q_y;
    logic signed [Q_W-1:0]   q_z;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    clipped;
  } qvr_out_t;

endpackage

// ===== sv/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a 3-vector by a fixed-point quaternion: v' = q * (0,v) * conj(q).
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_stall/in_data): quaternion w,x,y,z in signed
//   Q1.QUAT_FRAC_BITS and an integer vector x,y,z. No normalization is done;
//   a non-unit quaternion scales the result by |q|^2.
//   Output beat (out_valid/out_stall/out_data): rotated vector, each component
//   saturated, and clipped set when any component was clamped.
//   A taken beat moves through the stage registers in order, and out_valid
//   rises when it reaches the output register. One beat is taken every cycle
//   while in_stall is low; the four stages are products q*v, the sums giving
//   p = q*(0,v), products p*q, then sum, shift and saturate into the output
//   register.
//   Each stage moves when its successor is empty or moving, so bubbles close
//   up under a stall; in_stall rises only when every stage is full and the
//   receiver stalls. A stalled output beat holds unchanged.
//   Reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qvr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qvr_out_t out_data
);

  localparam int M1_W = Q_W + VEC_W;         // q * v product
  localparam int S1_W = M1_W + 2;            // three-term sum
  localparam int P_W  = S1_W - QUAT_FRAC_BITS;
  localparam int M2_W = P_W + Q_W;           // p * q product

  // quaternion slots
  localparam int QW = 0;
  localparam int QX = 1;
  localparam int QY = 2;
  localparam int QZ = 3;
  // vector slots
  localparam int VX = 0;
  localparam int VY = 1;
  localparam int VZ = 2;

  // handshake
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !out_valid_r || !out_stall;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_valid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;

  // stage 1: q * v products
  logic signed [M1_W-1:0] qe [4];
  logic signed [M1_W-1:0] ve [3];
  logic signed [M1_W-1:0] m1_nxt [12];
  logic signed [M1_W-1:0] m1_r   [12];
  logic signed [Q_W-1:0]  q1_r   [4];

  always_comb begin
    qe[QW] = M1_W'(in_data.q_w);
    qe[QX] = M1_W'(in_data.q_x);
    qe[QY] = M1_W'(in_data.q_y);
    qe[QZ] = M1_W'(in_data.q_z);
    ve[VX] = M1_W'(in_data.vec_x);
    ve[VY] = M1_W'(in_data.vec_y);
    ve[VZ] = M1_W'(in_data.vec_z);
    // pw terms
    m1_nxt[0]  = qe[QX] * ve[VX];
    m1_nxt[1]  = qe[QY] * ve[VY];
    m1_nxt[2]  = qe[QZ] * ve[VZ];
    // px = y*vz - z*vy + w*vx
    m1_nxt[3]  = qe[QY] * ve[VZ];
    m1_nxt[4]  = qe[QZ] * ve[VY];
    m1_nxt[5]  = qe[QW] * ve[VX];
    // py = z*vx - x*vz + w*vy
    m1_nxt[6]  = qe[QZ] * ve[VX];
    m1_nxt[7]  = qe[QX] * ve[VZ];
    m1_nxt[8]  = qe[QW] * ve[VY];
    // pz = x*vy - y*vx + w*vz
    m1_nxt[9]  = qe[QX] * ve[VY];
    m1_nxt[10] = qe[QY] * ve[VX];
    m1_nxt[11] = qe[QW] * ve[VZ];
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      m1_r     <= m1_nxt;
      q1_r[QW] <= in_data.q_w;
      q1_r[QX] <= in_data.q_x;
      q1_r[QY] <= in_data.q_y;
      q1_r[QZ] <= in_data.q_z;
    end
  end

  // stage 2: p = q * (0,v), floor shift
  logic signed [S1_W-1:0] s1 [4];
  logic signed [S1_W-1:0] s1_sh [4];
  logic signed [P_W-1:0]  p_r [4];
  logic signed [Q_W-1:0]  q2_r [4];

  always_comb begin
    s1[QW] = -(S1_W'(m1_r[0]) + S1_W'(m1_r[1]) + S1_W'(m1_r[2]));
    s1[QX] = S1_W'(m1_r[3]) - S1_W'(m1_r[4])  + S1_W'(m1_r[5]);
    s1[QY] = S1_W'(m1_r[6]) - S1_W'(m1_r[7])  + S1_W'(m1_r[8]);
    s1[QZ] = S1_W'(m1_r[9]) - S1_W'(m1_r[10]) + S1_W'(m1_r[11]);
    for (int i = 0; i < 4; i++) begin
      s1_sh[i] = s1[i] >>> QUAT_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= P_W'(s1_sh[i]);
      end
      q2_r <= q1_r;
    end
  end

  // stage 3: p * q products, grouped add, add, sub, sub per component
  logic signed [M2_W-1:0] pe [4];
  logic signed [M2_W-1:0] ce [4];
  logic signed [M2_W-1:0] m3_nxt [12];
  logic signed [M2_W-1:0] m3_r   [12];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pe[i] = M2_W'(p_r[i]);
      ce[i] = M2_W'(q2_r[i]);
    end
    // rx = px*w + pz*y - py*z - pw*x
    m3_nxt[0]  = pe[QX] * ce[QW];
    m3_nxt[1]  = pe[QZ] * ce[QY];
    m3_nxt[2]  = pe[QY] * ce[QZ];
    m3_nxt[3]  = pe[QW] * ce[QX];
    // ry = py*w + px*z - pz*x - pw*y
    m3_nxt[4]  = pe[QY] * ce[QW];
    m3_nxt[5]  = pe[QX] * ce[QZ];
    m3_nxt[6]  = pe[QZ] * ce[QX];
    m3_nxt[7]  = pe[QW] * ce[QY];
    // rz = pz*w + py*x - px*y - pw*z
    m3_nxt[8]  = pe[QZ] * ce[QW];
    m3_nxt[9]  = pe[QY] * ce[QX];
    m3_nxt[10] = pe[QX] * ce[QY];
    m3_nxt[11] = pe[QW] * ce[QZ];
  end

  always_ff @(posedge clk) begin
    if (adv3) m3_r <= m3_nxt;
  end

  // stage 4: combine, shift, saturate into the output register
  logic signed [VEC_W-1:0] rot [3];
  logic [2:0]              clip;
  qvr_out_t                out_data_r;

  for (genvar g = 0; g < 3; g++) begin : g_comp
    qvr_rot_comp #(
      .PROD_W    (M2_W),
      .FRAC_BITS (QUAT_FRAC_BITS)
    ) u_comp (
      .add_a (m3_r[4*g]),
      .add_b (m3_r[4*g+1]),
      .sub_a (m3_r[4*g+2]),
      .sub_b (m3_r[4*g+3]),
      .rot   (rot[g]),
      .clip  (clip[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_data_r.out_x   <= rot[VX];
      out_data_r.out_y   <= rot[VY];
      out_data_r.out_z   <= rot[VZ];
      out_data_r.clipped <= |clip;
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== sv/qvr_rot_comp.sv =====
// ----------------------------------------------------------------------------
// qvr_rot_comp
// One rotated component: sum of two products minus two products, floor shift
// by the fraction width, saturate to the vector width.
// ----------------------------------------------------------------------------
module qvr_rot_comp
  import qvr_pkg::*;
#(
  parameter int PROD_W    = 44,
  parameter int FRAC_BITS = 14
) (
  input  logic signed [PROD_W-1:0] add_a,
  input  logic signed [PROD_W-1:0] add_b,
  input  logic signed [PROD_W-1:0] sub_a,
  input  logic signed [PROD_W-1:0] sub_b,
  output logic signed [VEC_W-1:0]  rot,
  output logic                     clip
);

  localparam int SUM_W = PROD_W + 2;
  localparam int SH_W  = SUM_W - FRAC_BITS;
  localparam int RES_W = (SH_W > VEC_W) ? SH_W : VEC_W + 1;

  localparam logic signed [RES_W-1:0] SAT_HI =
    {{(RES_W-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_LO =
    {{(RES_W-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}};

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sh;
  logic signed [RES_W-1:0] res;

  always_comb begin
    sum = SUM_W'(add_a) + SUM_W'(add_b) - SUM_W'(sub_a) - SUM_W'(sub_b);
    sh  = sum >>> FRAC_BITS;
    // shifted value fits in SH_W bits, so the resize keeps it exact
    res = RES_W'(sh);
    priority if (res > SAT_HI) begin
      rot  = {1'b0, {(VEC_W-1){1'b1}}};
      clip = 1'b1;
    end else if (res < SAT_LO) begin
      rot  = {1'b1, {(VEC_W-1){1'b0}}};
      clip = 1'b1;
    end else begin
      rot  = res[VEC_W-1:0];
      clip = 1'b0;
    end
  end

endmodule

// ===== sv/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks of the quaternion vector rotator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qvr_checker
  import qvr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input qvr_out_t out_data
);

  localparam logic signed [VEC_W-1:0] V_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] V_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  logic clip_at_rail;
  logic in_beat;
  logic out_held;
  logic out_free;

  assign clip_at_rail =
    (out_data.out_x == V_MAX) || (out_data.out_x == V_MIN) ||
    (out_data.out_y == V_MAX) || (out_data.out_y == V_MIN) ||
    (out_data.out_z == V_MAX) || (out_data.out_z == V_MIN);

  assign in_beat  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign out_free = !out_stall;

  `QVR_ASSERT_NEXT(a_out_hold, out_held, out_valid, "output beat dropped under stall")
  `QVR_ASSERT_NEXT(a_out_stable, out_held, $stable(out_data), "stalled output beat changed")
  `QVR_ASSERT_SAME(a_no_backpressure, out_free, !in_stall, "input stalled while output free")
  `QVR_ASSERT_SAME(a_clip_rail, out_valid && out_data.clipped, clip_at_rail, "clip off rail")
  `QVR_ASSERT_NEXT(a_latency, in_beat ##1 out_free ##1 out_free ##1 out_free, out_valid, "no beat")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

// ===== tb/quaternion_vector_rotate_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb
// Self-checking bench for the fixed-point quaternion vector rotator. Each
// accepted beat is rotated by an exact integer model of q*(0,v)*conj(q) with
// floor shifts and 24-bit saturation, queued, and compared field by field
// with the output beats in order. Directed corners come first, then random
// beats under three idling mixes, then a long output hold-off that backs the
// pipe up into its input.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_tb;
  import qvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 14;
  localparam int RESET_CYC   = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYC   = 12;
  localparam int RANDOM_ITEMS = 400;
  localparam longint TIMEOUT_NS = 3_000_000;

  localparam logic signed [Q_W-1:0]   Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0]   Q_ONE   = Q_W'(1 << FRAC);
  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef enum int {SPAN_FULL, SPAN_NEAR_UNIT, SPAN_CORNER} span_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  qvr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qvr_out_t out_data;

  qvr_out_t rotated_q[$];
  int       fail_count    = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_requests = 0;
  int       holds_served  = 0;
  int       hold_left     = 0;

  quaternion_vector_rotate #(.QUAT_FRAC_BITS(FRAC)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [VEC_W-1:0] clamp_component(longint v, ref bit clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (VEC_W-1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return VEC_MAX;
    end
    if (v < lo) begin
      clip = 1'b1;
      return VEC_MIN;
    end
    return VEC_W'(v);
  endfunction

  function automatic qvr_out_t rotate_vector(qvr_in_t d);
    longint w, x, y, z, vx, vy, vz;
    longint cx, cy, cz;
    longint pw, px, py, pz;
    longint rx, ry, rz;
    bit clip;
    qvr_out_t r;
    w = d.q_w;  x = d.q_x;  y = d.q_y;  z = d.q_z;
    vx = d.vec_x;  vy = d.vec_y;  vz = d.vec_z;
    cx = -x;  cy = -y;  cz = -z;
    clip = 1'b0;
    // p = q * (0,v), floored
    pw = (-(x*vx + y*vy + z*vz)) >>> FRAC;
    px = (y*vz - z*vy + w*vx) >>> FRAC;
    py = (z*vx - x*vz + w*vy) >>> FRAC;
    pz = (x*vy - y*vx + w*vz) >>> FRAC;
    // imaginary part of p * conj(q), floored
    rx = (py*cz - pz*cy + pw*cx + px*w) >>> FRAC;
    ry = (pz*cx - px*cz + pw*cy + py*w) >>> FRAC;
    rz = (px*cy - py*cx + pw*cz + pz*w) >>> FRAC;
    r.out_x = clamp_component(rx, clip);
    r.out_y = clamp_component(ry, clip);
    r.out_z = clamp_component(rz, clip);
    r.clipped = clip;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic qvr_in_t make_item(int w, int x, int y, int z, int vx, int vy, int vz);
    qvr_in_t d;
    d.q_w = Q_W'(w);  d.q_x = Q_W'(x);  d.q_y = Q_W'(y);  d.q_z = Q_W'(z);
    d.vec_x = VEC_W'(vx);  d.vec_y = VEC_W'(vy);  d.vec_z = VEC_W'(vz);
    return d;
  endfunction

  function automatic logic signed [Q_W-1:0] pick_quat(span_e s);
    logic signed [Q_W-1:0] c;
    case (s)
      SPAN_FULL:      c = Q_W'($urandom);
      // keeps |q|^2 at or under one
      SPAN_NEAR_UNIT: c = Q_W'(int'($urandom_range(16384)) - 8192);
      default: begin
        case ($urandom_range(4))
          0:       c = Q_MAX;
          1:       c = Q_MIN;
          2:       c = '0;
          3:       c = Q_ONE;
          default: c = -Q_ONE;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [VEC_W-1:0] pick_vec(span_e s);
    logic signed [VEC_W-1:0] c;
    case (s)
      SPAN_FULL:      c = VEC_W'($urandom);
      SPAN_NEAR_UNIT: c = VEC_W'(int'($urandom_range(131072)) - 65536);
      default: begin
        case ($urandom_range(4))
          0:       c = VEC_MAX;
          1:       c = VEC_MIN;
          2:       c = '0;
          3:       c = '1;
          default: c = VEC_W'(1);
        endcase
      end
    endcase
    return c;
  endfunction

  // Offer one beat; queue its rotation when it is taken.
  task automatic send_beat(qvr_in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rotated_q.push_back(rotate_vector(d));
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
  endtask

  task automatic test_directed();
    send_beat(make_item(Q_ONE, 0, 0, 0, 1000, -2000, 3000));
    send_beat(make_item(Q_ONE, 0, 0, 0, VEC_MAX, VEC_MAX, VEC_MAX));
    send_beat(make_item(Q_ONE, 0, 0, 0, VEC_MIN, VEC_MIN, VEC_MIN));
    send_beat(make_item(0, 0, 0, 0, VEC_MAX, VEC_MIN, 12345));
    // quarter turn about z
    send_beat(make_item(11585, 0, 0, 11585, 1 << 20, 0, 0));
    send_beat(make_item(11585, 0, 0, 11585, 0, -(1 << 20), 77));
    // half turns about each axis
    send_beat(make_item(0, Q_ONE, 0, 0, 100, 200, 300));
    send_beat(make_item(0, 0, Q_ONE, 0, 100, 200, 300));
    send_beat(make_item(0, 0, 0, Q_ONE, 100, 200, 300));
    // oversized quaternions drive saturation both ways
    send_beat(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, VEC_MAX, VEC_MAX, VEC_MAX));
    send_beat(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, VEC_MIN, VEC_MIN, VEC_MIN));
    send_beat(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 3, -4, 5));
    send_beat(make_item(Q_MIN, 0, 0, 0, 5, -7, VEC_MAX));
    // most negative component, negated in the conjugate
    send_beat(make_item(0, Q_MIN, 0, 0, 1, 1, 1));
    send_beat(make_item(0, 0, Q_MIN, 0, -1, -1, -1));
    send_beat(make_item(0, 0, 0, Q_MIN, 3, -3, 0));
    send_beat(make_item(Q_MAX, Q_MIN, Q_MAX, Q_MIN, VEC_MIN, VEC_MAX, VEC_MIN));
    // small negative intermediates exercise floor rounding
    send_beat(make_item(11585, 11585, 0, 0, -1, -1, -1));
    send_beat(make_item(8192, 8192, 8192, 8192, -3, 5, -7));
    send_beat(make_item(-1, -1, -1, -1, VEC_MAX, VEC_MAX, VEC_MAX));
    send_beat(make_item(12345, -23456, 3456, -456, 0, 0, 0));
    send_beat(make_item(-Q_ONE, 0, 0, 0, -8388607, 8388606, -2));
  endtask

  task automatic test_random(int count);
    qvr_in_t d;
    span_e qs, vs;
    repeat (count) begin
      qs = span_e'($urandom_range(2));
      vs = span_e'($urandom_range(2));
      d.q_w = pick_quat(qs);
      d.q_x = pick_quat(qs);
      d.q_y = pick_quat(qs);
      d.q_z = pick_quat(qs);
      d.vec_x = pick_vec(vs);
      d.vec_y = pick_vec(vs);
      d.vec_z = pick_vec(vs);
      send_beat(d);
    end
  endtask

  // Hold the output off long enough for the pipe to fill and stall its input.
  task automatic test_input_backpressure();
    set_idling(0, 0);
    hold_requests <= hold_requests + 1;
    test_random(60);
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    qvr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual x=%0d y=%0d z=%0d clipped=%0b",
                 $time, out_data.out_x, out_data.out_y, out_data.out_z, out_data.clipped);
        fail_count++;
      end else begin
        want = rotated_q.pop_front();
        compare_field("out_x", want.out_x, out_data.out_x);
        compare_field("out_y", want.out_y, out_data.out_y);
        compare_field("out_z", want.out_z, out_data.out_z);
        compare_field("clipped", want.clipped, out_data.clipped);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(22, 51);
    test_directed();
    test_random(RANDOM_ITEMS);
    set_idling(51, 22);
    test_random(RANDOM_ITEMS);
    set_idling(0, 0);
    test_random(RANDOM_ITEMS);
    test_input_backpressure();

    in_valid <= 1'b0;
    set_idling(0, 30);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
